// ===== hw/rtl/spsc_pkg.sv =====
// ----------------------------------------------------------------------------
// spsc_pkg
// Types and constants shared by the segmented prime sieve counter.
// ----------------------------------------------------------------------------
package spsc_pkg;

	localparam int RANGE_W = 24;
	localparam int COUNT_W = 21;
	localparam int SIEVE_W = 12;
	localparam int SEG_W   = 15;
	localparam int SLOT_W  = 10;
	localparam int POS_W   = 25;
	localparam int IDX_W   = 13;
	localparam int DIV_W   = 5;

	localparam logic [IDX_W-1:0]  SMALL_LAST  = 13'd4095;
	localparam logic [IDX_W-1:0]  SMALL_LIMIT = 13'd4096;
	localparam logic [IDX_W-1:0]  SMALL_ROOT  = 13'd64;
	localparam logic [IDX_W-1:0]  FIRST_PRIME = 13'd2;
	localparam logic [SLOT_W-1:0] PRIME_SLOTS = 10'd564;
	localparam logic [POS_W-1:0]  RANGE_LIMIT = 25'd16777216;
	localparam logic [POS_W-1:0]  SEG_SPAN    = 25'd32768;
	localparam logic [POS_W-1:0]  SEG_LAST    = 25'd32767;
	localparam logic [DIV_W-1:0]  DIV_TOP     = 5'd23;

	typedef enum logic [4:0] {
		S_FILL, S_SV_INIT, S_SV_RD, S_SV_CHK, S_SV_MARK, S_LS_INIT, S_LS_RD,
		S_LS_TAKE, S_IDLE, S_CHECK, S_SEG, S_SFILL, S_PINIT, S_PRD, S_PSQ,
		S_PCHK, S_DIV, S_START, S_CLR, S_CNT0, S_CNT, S_DRAIN, S_SNEXT, S_OUT
	} state_t;

	typedef struct packed {
		logic fill_small;
		logic sv_start;
		logic sv_read;
		logic sv_mark_start;
		logic sv_mark;
		logic sv_next;
		logic ls_start;
		logic ls_take;
		logic req_load;
		logic set_err;
		logic seg_start;
		logic seg_fill;
		logic pr_start;
		logic pr_read;
		logic pr_sq;
		logic div_step;
		logic st_start;
		logic clr;
		logic pr_next;
		logic cnt_start;
		logic cnt_step;
		logic seg_next;
	} cmd_t;

	typedef struct packed {
		logic init_last;
		logic sv_bit;
		logic sv_done;
		logic mark_last;
		logic ls_last;
		logic range_bad;
		logic fill_last;
		logic pr_end;
		logic sq_gt;
		logic div_last;
		logic clr_done;
		logic cnt_last;
		logic seg_last;
	} status_t;

endpackage

// ===== hw/rtl/spsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// spsc_ctrl
// Sequencer for start-up sieve, per-segment sieving and counting.
// ----------------------------------------------------------------------------
module spsc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  spsc_pkg::status_t st,
	output spsc_pkg::cmd_t    cmd
);

	spsc_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spsc_pkg::S_FILL;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			spsc_pkg::S_FILL:    if (st.init_last) state_nxt = spsc_pkg::S_SV_INIT;
			spsc_pkg::S_SV_INIT: state_nxt = spsc_pkg::S_SV_RD;
			spsc_pkg::S_SV_RD:   state_nxt = st.sv_done ? spsc_pkg::S_LS_INIT
			                                            : spsc_pkg::S_SV_CHK;
			spsc_pkg::S_SV_CHK:  state_nxt = st.sv_bit ? spsc_pkg::S_SV_MARK
			                                           : spsc_pkg::S_SV_RD;
			spsc_pkg::S_SV_MARK: if (st.mark_last) state_nxt = spsc_pkg::S_SV_RD;
			spsc_pkg::S_LS_INIT: state_nxt = spsc_pkg::S_LS_RD;
			spsc_pkg::S_LS_RD:   state_nxt = spsc_pkg::S_LS_TAKE;
			spsc_pkg::S_LS_TAKE: state_nxt = st.ls_last ? spsc_pkg::S_IDLE
			                                            : spsc_pkg::S_LS_RD;
			spsc_pkg::S_IDLE:    if (in_valid) state_nxt = spsc_pkg::S_CHECK;
			spsc_pkg::S_CHECK:   state_nxt = st.range_bad ? spsc_pkg::S_OUT
			                                              : spsc_pkg::S_SEG;
			spsc_pkg::S_SEG:     state_nxt = spsc_pkg::S_SFILL;
			spsc_pkg::S_SFILL:   if (st.fill_last) state_nxt = spsc_pkg::S_PINIT;
			spsc_pkg::S_PINIT:   state_nxt = spsc_pkg::S_PRD;
			spsc_pkg::S_PRD:     state_nxt = st.pr_end ? spsc_pkg::S_CNT0
			                                           : spsc_pkg::S_PSQ;
			spsc_pkg::S_PSQ:     state_nxt = spsc_pkg::S_PCHK;
			spsc_pkg::S_PCHK:    state_nxt = st.sq_gt ? spsc_pkg::S_CNT0
			                                          : spsc_pkg::S_DIV;
			spsc_pkg::S_DIV:     if (st.div_last) state_nxt = spsc_pkg::S_START;
			spsc_pkg::S_START:   state_nxt = spsc_pkg::S_CLR;
			spsc_pkg::S_CLR:     if (st.clr_done) state_nxt = spsc_pkg::S_PRD;
			spsc_pkg::S_CNT0:    state_nxt = spsc_pkg::S_CNT;
			spsc_pkg::S_CNT:     if (st.cnt_last) state_nxt = spsc_pkg::S_DRAIN;
			spsc_pkg::S_DRAIN:   state_nxt = spsc_pkg::S_SNEXT;
			spsc_pkg::S_SNEXT:   state_nxt = st.seg_last ? spsc_pkg::S_OUT
			                                             : spsc_pkg::S_SEG;
			spsc_pkg::S_OUT:     if (out_ready) state_nxt = spsc_pkg::S_IDLE;
			default:             state_nxt = spsc_pkg::S_FILL;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			spsc_pkg::S_FILL:    cmd.fill_small = 1'b1;
			spsc_pkg::S_SV_INIT: cmd.sv_start = 1'b1;
			spsc_pkg::S_SV_RD:   cmd.sv_read = !st.sv_done;
			spsc_pkg::S_SV_CHK: begin
				cmd.sv_mark_start = st.sv_bit;
				cmd.sv_next       = !st.sv_bit;
			end
			spsc_pkg::S_SV_MARK: begin
				cmd.sv_mark = 1'b1;
				cmd.sv_next = st.mark_last;
			end
			spsc_pkg::S_LS_INIT: cmd.ls_start = 1'b1;
			spsc_pkg::S_LS_RD:   cmd.sv_read = 1'b1;
			spsc_pkg::S_LS_TAKE: cmd.ls_take = 1'b1;
			spsc_pkg::S_IDLE: begin
				in_ready     = 1'b1;
				cmd.req_load = in_valid;
			end
			spsc_pkg::S_CHECK:   cmd.set_err = st.range_bad;
			spsc_pkg::S_SEG:     cmd.seg_start = 1'b1;
			spsc_pkg::S_SFILL:   cmd.seg_fill = 1'b1;
			spsc_pkg::S_PINIT:   cmd.pr_start = 1'b1;
			spsc_pkg::S_PRD:     cmd.pr_read = !st.pr_end;
			spsc_pkg::S_PSQ:     cmd.pr_sq = 1'b1;
			spsc_pkg::S_PCHK:    ;
			spsc_pkg::S_DIV:     cmd.div_step = 1'b1;
			spsc_pkg::S_START:   cmd.st_start = 1'b1;
			spsc_pkg::S_CLR: begin
				cmd.clr     = !st.clr_done;
				cmd.pr_next = st.clr_done;
			end
			spsc_pkg::S_CNT0:    cmd.cnt_start = 1'b1;
			spsc_pkg::S_CNT:     cmd.cnt_step = 1'b1;
			spsc_pkg::S_DRAIN:   ;
			spsc_pkg::S_SNEXT:   cmd.seg_next = !st.seg_last;
			spsc_pkg::S_OUT:     out_valid = 1'b1;
			default:             ;
		endcase
	end

endmodule

// ===== hw/rtl/spsc_datapath.sv =====
// ----------------------------------------------------------------------------
// spsc_datapath
// Sieve memories, prime table, remainder unit and counters.
// ----------------------------------------------------------------------------
module spsc_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  spsc_pkg::cmd_t                 cmd,
	output spsc_pkg::status_t              st,
	input  logic [spsc_pkg::RANGE_W-1:0]   range_low,
	input  logic [spsc_pkg::RANGE_W-1:0]   range_high,
	output logic [spsc_pkg::COUNT_W-1:0]   prime_count,
	output logic                           range_error
);

	logic small_mem [0:(1 << spsc_pkg::SIEVE_W)-1];
	logic [spsc_pkg::SIEVE_W-1:0] prime_mem [0:564-1];
	logic seg_mem [0:(1 << spsc_pkg::SEG_W)-1];

	logic [spsc_pkg::IDX_W-1:0]   i_q, j_q;
	logic                         sbit_q;
	logic [spsc_pkg::SLOT_W-1:0]  ptotal_q, pi_q;
	logic [spsc_pkg::SIEVE_W-1:0] pdata_q, p_q, rem_q;
	logic [2*spsc_pkg::SIEVE_W-1:0] sq_q;
	logic [spsc_pkg::RANGE_W-1:0] lo_q, hi_q;
	logic [spsc_pkg::POS_W-1:0]   base_q, seghi_q, k_q;
	logic [spsc_pkg::SEG_W-1:0]   off_q;
	logic [spsc_pkg::DIV_W-1:0]   div_q;
	logic [spsc_pkg::COUNT_W-1:0] total_q;
	logic                         err_q;
	logic                         rd_v_s1, seg_bit_s1;

	logic [spsc_pkg::POS_W-1:0]   lo_x, hi_x, seg_end, len_m1, k_off;
	logic [spsc_pkg::SIEVE_W:0]   rem_t;

	assign lo_x    = {1'b0, lo_q};
	assign hi_x    = {1'b0, hi_q};
	assign seg_end = base_q + spsc_pkg::SEG_LAST;
	assign len_m1  = seghi_q - base_q;
	assign k_off   = k_q - base_q;
	assign rem_t   = {rem_q, base_q[div_q]};

	assign st.init_last = (i_q == spsc_pkg::SMALL_LAST);
	assign st.sv_bit    = sbit_q;
	assign st.sv_done   = (i_q >= spsc_pkg::SMALL_ROOT);
	assign st.mark_last = ((j_q + i_q) >= spsc_pkg::SMALL_LIMIT);
	assign st.ls_last   = (i_q == spsc_pkg::SMALL_LAST);
	assign st.range_bad = (lo_x > hi_x) || (hi_x >= spsc_pkg::RANGE_LIMIT);
	assign st.fill_last = (off_q == len_m1[spsc_pkg::SEG_W-1:0]);
	assign st.pr_end    = (pi_q >= ptotal_q);
	assign st.sq_gt     = ({1'b0, sq_q} > seghi_q);
	assign st.div_last  = (div_q == '0);
	assign st.clr_done  = (k_q > seghi_q);
	assign st.cnt_last  = (off_q == len_m1[spsc_pkg::SEG_W-1:0]);
	assign st.seg_last  = ((base_q + spsc_pkg::SEG_SPAN) > hi_x);

	assign prime_count = total_q;
	assign range_error = err_q;

	always_ff @(posedge clk) begin
		if (cmd.fill_small) begin
			small_mem[i_q[spsc_pkg::SIEVE_W-1:0]] <= (i_q >= spsc_pkg::FIRST_PRIME);
		end else if (cmd.sv_mark) begin
			small_mem[j_q[spsc_pkg::SIEVE_W-1:0]] <= 1'b0;
		end
		if (cmd.sv_read) begin
			sbit_q <= small_mem[i_q[spsc_pkg::SIEVE_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ls_take && sbit_q && (ptotal_q < spsc_pkg::PRIME_SLOTS)) begin
			prime_mem[ptotal_q] <= i_q[spsc_pkg::SIEVE_W-1:0];
		end
		if (cmd.pr_read) begin
			pdata_q <= prime_mem[pi_q];
		end
	end

	// Numbers 0 and 1 are written as composite while the segment is filled.
	always_ff @(posedge clk) begin
		if (cmd.seg_fill) begin
			seg_mem[off_q] <= ((base_q + {10'd0, off_q}) > 25'd1);
		end else if (cmd.clr) begin
			seg_mem[k_off[spsc_pkg::SEG_W-1:0]] <= 1'b0;
		end
		seg_bit_s1 <= seg_mem[off_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q      <= '0;
			ptotal_q <= '0;
			rd_v_s1  <= 1'b0;
			err_q    <= 1'b0;
			total_q  <= '0;
		end else begin
			rd_v_s1 <= cmd.cnt_step;
			if (cmd.fill_small || cmd.sv_next || cmd.ls_take) begin
				i_q <= i_q + 13'd1;
			end else if (cmd.sv_start || cmd.ls_start) begin
				i_q <= spsc_pkg::FIRST_PRIME;
			end
			if (cmd.ls_start) begin
				ptotal_q <= '0;
			end else if (cmd.ls_take && sbit_q && (ptotal_q < spsc_pkg::PRIME_SLOTS)) begin
				ptotal_q <= ptotal_q + 10'd1;
			end
			if (cmd.req_load) begin
				err_q   <= 1'b0;
				total_q <= '0;
			end else begin
				if (cmd.set_err) begin
					err_q <= 1'b1;
				end
				if (rd_v_s1 && seg_bit_s1) begin
					total_q <= total_q + 21'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sv_mark_start) begin
			j_q <= i_q * i_q;
		end else if (cmd.sv_mark) begin
			j_q <= j_q + i_q;
		end
		if (cmd.req_load) begin
			lo_q <= range_low;
			hi_q <= range_high;
		end
		if (cmd.set_err || cmd.req_load) begin
			base_q <= {1'b0, range_low};
		end else if (cmd.seg_next) begin
			base_q <= base_q + spsc_pkg::SEG_SPAN;
		end
		if (cmd.seg_start) begin
			seghi_q <= (seg_end > hi_x) ? hi_x : seg_end;
		end
		if (cmd.seg_start || cmd.cnt_start) begin
			off_q <= '0;
		end else if (cmd.seg_fill || cmd.cnt_step) begin
			off_q <= off_q + 15'd1;
		end
		if (cmd.pr_start) begin
			pi_q <= '0;
		end else if (cmd.pr_next) begin
			pi_q <= pi_q + 10'd1;
		end
		if (cmd.pr_sq) begin
			p_q   <= pdata_q;
			sq_q  <= {12'd0, pdata_q} * {12'd0, pdata_q};
			rem_q <= '0;
			div_q <= spsc_pkg::DIV_TOP;
		end else if (cmd.div_step) begin
			// One restoring step of base mod p, most significant bit first.
			rem_q <= (rem_t >= {1'b0, p_q}) ? 12'(rem_t - {1'b0, p_q}) : rem_t[11:0];
			div_q <= div_q - 5'd1;
		end
		if (cmd.st_start) begin
			if (base_q <= {1'b0, sq_q}) begin
				k_q <= {1'b0, sq_q};
			end else if (rem_q == '0) begin
				k_q <= base_q;
			end else begin
				k_q <= base_q + {13'd0, p_q - rem_q};
			end
		end else if (cmd.clr) begin
			k_q <= k_q + {13'd0, p_q};
		end
	end

endmodule

// ===== hw/rtl/segmented_prime_sieve_counter.sv =====
// ----------------------------------------------------------------------------
// segmented_prime_sieve_counter
// Counts the primes in an inclusive range with a segmented sieve.
// ----------------------------------------------------------------------------
// The input stream carries one request word: range_low and range_high. The
// output stream returns one word per request: the prime count, with
// range_error on tuser. A rejected range gives count 0 and error 1.
// After reset the block sieves the numbers below 4096 and lists the 564
// primes found, and no request is taken until it is done. A request is
// then handled one at a time: each segment of up to 32768 numbers is
// filled, then base mod p is found and the multiples are cleared for each
// small prime p with p*p not above the segment's last number, and then
// the segment is counted.
// The result word is held until the receiver takes it, and the next
// request is taken only after that.
// ----------------------------------------------------------------------------
module segmented_prime_sieve_counter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // [23:0] range_low, [47:24] range_high
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [20:0] prime_count, [23:21] zero
	output logic        m_axis_tuser    // [0] range_error
);

	spsc_pkg::cmd_t    cmd;
	spsc_pkg::status_t st;
	logic [spsc_pkg::COUNT_W-1:0] count;

	spsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.st        (st),
		.cmd       (cmd)
	);

	spsc_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.range_low   (s_axis_tdata[23:0]),
		.range_high  (s_axis_tdata[47:24]),
		.prime_count (count),
		.range_error (m_axis_tuser)
	);

	assign m_axis_tdata = {3'b000, count};

`ifndef NO_ASSERTIONS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[20:0] == 21'd0)
		else $error("range error with nonzero count");

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("ready for input while result pending");

	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !m_axis_tvalid)
		else $error("request not processed after acceptance");
`endif

endmodule

// ===== tb/sv/segmented_prime_sieve_counter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segmented_prime_sieve_counter_tb
// Self-checking bench for the segmented prime sieve counter.
// ----------------------------------------------------------------------------
// Range requests go in on the input stream. Prime counts come back on the
// output stream. Each is checked against a known or a trial-division
// count of the same range. The bench opens with a short table of edge
// ranges. Random ranges follow; most are small, since the block fills
// and counts every number of a request. Both streams idle at random. The
// receiver holds off once for a long stretch; the block stalls its input.
// ----------------------------------------------------------------------------
module segmented_prime_sieve_counter_tb;

	localparam int TOP = 16777215;

	typedef struct {
		logic [spsc_pkg::COUNT_W-1:0] count;
		logic                         err;
	} count_word_t;

	typedef struct {
		int unsigned lo;
		int unsigned hi;
		bit          known;
		int unsigned count;
		bit          err;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [47:0]       s_axis_tdata = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [23:0]       m_axis_tdata;
	logic              m_axis_tuser;

	count_word_t       expected_counts[$];
	int unsigned       trial_primes[$];
	int                mismatches = 0;
	int                results_seen = 0;
	int                errors_seen = 0;
	int                words_sent = 0;
	bit                stimulus_done = 1'b0;

	segmented_prime_sieve_counter uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always #1 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic bit is_prime(input int unsigned n);
		if (n < 2) begin
			return 1'b0;
		end
		foreach (trial_primes[i]) begin
			if (trial_primes[i] * trial_primes[i] > n) begin
				return 1'b1;
			end
			if (n % trial_primes[i] == 0) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	function automatic count_word_t predict_prime_count(input int unsigned lo,
			input int unsigned hi);
		count_word_t w;
		int unsigned total;
		total = 0;
		if (lo > hi) begin
			w.count = '0;
			w.err   = 1'b1;
			return w;
		end
		for (int unsigned n = lo; n <= hi; n++) begin
			if (is_prime(n)) begin
				total++;
			end
		end
		w.count = total[spsc_pkg::COUNT_W-1:0];
		w.err   = 1'b0;
		return w;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 60);
	endfunction

	// One request word. The word is accepted at the edge that follows a
	// falling edge at which tready is seen high.
	task automatic send_range(input int unsigned lo, input int unsigned hi);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {hi[23:0], lo[23:0]};
		@(negedge clk);
		while (!s_axis_tready) @(negedge clk);
		@(posedge clk);
		words_sent++;
	endtask

	initial begin
		stim_row_t   rows[$];
		count_word_t w;
		int          r;
		int unsigned lo;
		int unsigned hi;

		for (int unsigned n = 2; n < 4096; n++) begin
			bit p;
			p = 1'b1;
			foreach (trial_primes[i]) begin
				if (n % trial_primes[i] == 0) begin
					p = 1'b0;
				end
			end
			if (p) begin
				trial_primes.push_back(n);
			end
		end

		rows = '{
			'{0, 0, 1, 0, 0}, '{0, 1, 1, 0, 0}, '{1, 1, 1, 0, 0},
			'{0, 2, 1, 1, 0}, '{2, 2, 1, 1, 0}, '{1, 10, 1, 4, 0},
			'{0, 100, 1, 25, 0}, '{4, 4, 1, 0, 0}, '{5, 1, 1, 0, 1},
			'{TOP, 0, 1, 0, 1}, '{TOP, TOP, 1, 0, 0}, '{1, 0, 1, 0, 1},
			'{TOP - 300, TOP, 0, 0, 0}, '{16752649, 16752649, 0, 0, 0},
			'{4093, 4099, 0, 0, 0}, '{0, 32768, 0, 0, 0},
			'{32700, 32900, 0, 0, 0}, '{8388608, 8388700, 0, 0, 0},
			'{5592405, 5592500, 0, 0, 0}, '{10922666, 10922666, 0, 0, 0}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (rows[i]) begin
			if (rows[i].known) begin
				w.count = rows[i].count[spsc_pkg::COUNT_W-1:0];
				w.err   = rows[i].err;
			end else begin
				w = predict_prime_count(rows[i].lo, rows[i].hi);
			end
			expected_counts.push_back(w);
			send_range(rows[i].lo, rows[i].hi);
		end

		// Let the block drain completely before the random part.
		s_axis_tvalid <= 1'b0;
		while (expected_counts.size() != 0) @(posedge clk);

		for (int k = 0; k < 80; k++) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				lo = $urandom_range(1, TOP);
				hi = $urandom_range(0, lo - 1);
			end else if (r < 70) begin
				lo = $urandom_range(0, 20000);
				hi = lo + $urandom_range(0, 300);
			end else if (r < 92) begin
				lo = $urandom_range(0, TOP - 200);
				hi = lo + $urandom_range(0, 200);
			end else begin
				hi = TOP;
				lo = hi - $urandom_range(0, 500);
			end
			expected_counts.push_back(predict_prime_count(lo, hi));
			send_range(lo, hi);
		end
		s_axis_tvalid <= 1'b0;
		stimulus_done = 1'b1;
	end

	initial begin
		int g;
		repeat (10) @(posedge clk);
		forever begin
			if (results_seen == 4) begin
				// Long hold-off while the sender keeps a word waiting.
				m_axis_tready <= 1'b0;
				repeat (3000) @(posedge clk);
			end else begin
				g = gap_len();
				if (g > 0) begin
					m_axis_tready <= 1'b0;
					repeat (g) @(posedge clk);
				end
			end
			m_axis_tready <= 1'b1;
			@(negedge clk);
			while (!m_axis_tvalid) @(negedge clk);
			if (expected_counts.size() == 0) begin
				report_mismatch("result word with no request waiting");
			end else begin
				count_word_t w;
				w = expected_counts.pop_front();
				if (m_axis_tdata[spsc_pkg::COUNT_W-1:0] !== w.count) begin
					report_mismatch($sformatf("prime_count %0d, expected %0d",
						m_axis_tdata[spsc_pkg::COUNT_W-1:0], w.count));
				end
				if (m_axis_tdata[23:spsc_pkg::COUNT_W] !== '0) begin
					report_mismatch("pad bits of the result word not zero");
				end
				if (m_axis_tuser !== w.err) begin
					report_mismatch($sformatf("range_error %0b, expected %0b",
						m_axis_tuser, w.err));
				end
			end
			if (m_axis_tuser === 1'b1) begin
				errors_seen++;
			end
			results_seen++;
			@(posedge clk);
		end
	end

	initial begin
		wait (stimulus_done);
		while (expected_counts.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Sent %0d range requests, %0d results checked, %0d rejected ranges.",
			words_sent, results_seen, errors_seen);
		$display("Covered edge ranges, a two-segment range and top-of-range requests.");
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("Timeout with %0d results outstanding.", expected_counts.size());
		$display("FAIL");
		$finish;
	end

endmodule
